/* rtl/bitmap_to_point_coordinates_assert.svh */
// Assertion macros shared by the bitmap to point coordinates RTL.
// Included by files that carry concurrent checks; needs no package.
`ifndef BITMAP_TO_POINT_COORDINATES_ASSERT_SVH
`define BITMAP_TO_POINT_COORDINATES_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define BTPC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("btpc: check failed");

// Next-cycle implication, disabled while reset is asserted
`define BTPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("btpc: check failed");

`endif

/* rtl/btpc_pkg.sv */
// Package for the bitmap to point coordinates block: widths, reset values,
// register indexes and the item passed from the front end to the emitter.
// No dependencies.
package btpc_pkg;

	localparam int MAX_DIM_DEF    = 4;
	localparam int COORD_BITS_DEF = 16;
	localparam int FIELD_W        = 16;
	localparam int BYTE_W         = 8;
	localparam int POS_W          = 13;
	localparam int BIT_IDX_W      = 3;
	localparam int DIM_W          = 3;
	localparam int CFG_IDX_W      = 3;

	localparam logic [DIM_W-1:0]   DIM_RESET  = 3'd2;
	localparam logic [FIELD_W-1:0] SIZE_RESET = 16'd64;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DIMENSION = 3'd0,
		CFG_SIZE_X    = 3'd1,
		CFG_SIZE_Y    = 3'd2,
		CFG_SIZE_Z    = 3'd3,
		CFG_SIZE_W    = 3'd4
	} cfg_idx_t;

	// One byte's pending work: set bits still to emit and shared coordinates
	typedef struct packed {
		logic [BYTE_W-1:0]  mask;
		logic [FIELD_W-1:0] base;
		logic [FIELD_W-1:0] y;
		logic [FIELD_W-1:0] z;
		logic [FIELD_W-1:0] w;
	} item_t;

endpackage

/* rtl/btpc_emit.sv */
// Point emitter: holds one byte's set bits and sends one point per cycle
// while the receiver is not stalling, lowest bit first, through a registered
// output. Uses btpc_pkg and the assertion macro header.
`include "bitmap_to_point_coordinates_assert.svh"

module btpc_emit #(
	parameter int COORD_BITS = btpc_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_ready,
	input  btpc_pkg::item_t              item,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [btpc_pkg::FIELD_W-1:0] point_x,
	output logic [btpc_pkg::FIELD_W-1:0] point_y,
	output logic [btpc_pkg::FIELD_W-1:0] point_z,
	output logic [btpc_pkg::FIELD_W-1:0] point_w,
	output logic                         last_of_byte
);

	localparam int XW = (COORD_BITS < btpc_pkg::FIELD_W) ? COORD_BITS : btpc_pkg::FIELD_W;

	logic                              valid_s1;
	btpc_pkg::item_t                   item_s1;
	logic [btpc_pkg::BYTE_W-1:0]       rem;
	logic [btpc_pkg::BIT_IDX_W-1:0]    idx;
	logic [btpc_pkg::FIELD_W-1:0]      x_sum;
	logic [btpc_pkg::FIELD_W-1:0]      x_out;
	logic                              out_free;
	logic                              pop;
	logic                              out_valid_q;
	logic [btpc_pkg::FIELD_W-1:0]      x_q, y_q, z_q, w_q;
	logic                              last_q;

	// Lowest set bit and what remains after it
	always_comb begin
		idx = '0;
		for (int b = btpc_pkg::BYTE_W - 1; b >= 0; b--) begin
			if (item_s1.mask[b]) begin
				idx = btpc_pkg::BIT_IDX_W'(b);
			end
		end
		rem   = item_s1.mask & (item_s1.mask - 8'd1);
		x_sum = item_s1.base + btpc_pkg::FIELD_W'(idx);
		x_out = btpc_pkg::FIELD_W'(x_sum[XW-1:0]);
	end

	// Handshake: pop a point whenever the output slot is free or draining
	assign out_free   = !out_valid_q || out_ready;
	assign pop        = valid_s1 && out_free;
	assign item_ready = !valid_s1 || (pop && rem == '0);

	// Pending byte stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (pop && rem == '0) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end else if (pop) begin
			item_s1.mask <= rem;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			x_q    <= x_out;
			y_q    <= item_s1.y;
			z_q    <= item_s1.z;
			w_q    <= item_s1.w;
			last_q <= (rem == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign point_x      = x_q;
	assign point_y      = y_q;
	assign point_z      = z_q;
	assign point_w      = w_q;
	assign last_of_byte = last_q;

	// Checks
	`BTPC_ASSERT_NOW(a_pending_nonzero, clk, arst_n, valid_s1, item_s1.mask != '0)
	`BTPC_ASSERT_NEXT(a_pop_fills_out, clk, arst_n, pop, out_valid_q)
	`BTPC_ASSERT_NEXT(a_last_flag, clk, arst_n, pop, last_q == $past(rem == '0))

endmodule

/* rtl/bitmap_to_point_coordinates.sv */
// Top level of the bitmap to point coordinates block: configuration
// registers, line position and row counter. Uses btpc_pkg, btpc_emit and
// the assertion macro header.
//
// Usage:
//  - Input channel in_valid/in_ready carries data_byte, one bitmap byte per
//    transfer, least significant bit at the lowest x.
//  - Output channel out_valid/out_ready carries one point per transfer:
//    point_x..point_w and last_of_byte on the final point of a byte.
//  - Configuration channel cfg_valid/cfg_ready writes register cfg_index
//    (dimension, size_x, size_y, size_z, size_w) with cfg_data; it is always
//    ready, and the user must write it only while the block is idle; the
//    block itself does not enforce this.
//  - The first point of a byte passes the pending-byte stage, then the
//    output register, before it is presented.
//  - Throughput: one byte per cycle while bytes hold at most one point to
//    emit and the receiver does not stall; a byte with more points holds
//    the emitter until its last leaves: the single output register takes
//    one point per cycle. Bytes with no point skip the emitter but, like
//    any byte, wait while the pending stage holds a byte that is not leaving.
//  - Reset clears the line position and row counter, sets dimension to 2
//    and all sizes to 64, and empties both stages.
//  - When the receiver stalls, the output point holds, one further byte
//    waits in the pending stage and in_ready drops until it drains.
`include "bitmap_to_point_coordinates_assert.svh"

module bitmap_to_point_coordinates #(
	parameter int MAX_DIM    = btpc_pkg::MAX_DIM_DEF,
	parameter int COORD_BITS = btpc_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [btpc_pkg::BYTE_W-1:0]    data_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [btpc_pkg::FIELD_W-1:0]   point_x,
	output logic [btpc_pkg::FIELD_W-1:0]   point_y,
	output logic [btpc_pkg::FIELD_W-1:0]   point_z,
	output logic [btpc_pkg::FIELD_W-1:0]   point_w,
	output logic                           last_of_byte,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [btpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [btpc_pkg::FIELD_W-1:0]   cfg_data
);

	localparam int NUM_DIGITS = (MAX_DIM > 1) ? MAX_DIM - 1 : 1;
	localparam int DW_MIN     = $clog2(MAX_DIM + 1);
	localparam int DW         = (DW_MIN > btpc_pkg::DIM_W) ? DW_MIN : btpc_pkg::DIM_W;
	localparam int CMP_W      = ((COORD_BITS > btpc_pkg::FIELD_W) ? COORD_BITS
	                            : btpc_pkg::FIELD_W) + 1;

	// Configuration registers
	logic [btpc_pkg::DIM_W-1:0]   dimension_q;
	logic [btpc_pkg::FIELD_W-1:0] size_x_q, size_y_q, size_z_q, size_w_q;

	// Line position and row counter
	logic [btpc_pkg::POS_W-1:0]                  pos_q;
	logic [NUM_DIGITS-1:0][COORD_BITS-1:0]       digit_q;
	logic [NUM_DIGITS-1:0][COORD_BITS-1:0]       digit_d;

	logic [DW-1:0]                dims;
	logic [btpc_pkg::FIELD_W-1:0] base;
	logic [btpc_pkg::FIELD_W-1:0] diff;
	logic                         in_line;
	logic                         line_end;
	logic [btpc_pkg::BYTE_W-1:0]  bit_ok;
	logic [btpc_pkg::BYTE_W-1:0]  mask;
	logic [btpc_pkg::FIELD_W-1:0] coord [3];
	btpc_pkg::item_t              item;
	logic                         item_ready;
	logic                         accept;

	assign cfg_ready = 1'b1;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dimension_q <= btpc_pkg::DIM_RESET;
			size_x_q    <= btpc_pkg::SIZE_RESET;
			size_y_q    <= btpc_pkg::SIZE_RESET;
			size_z_q    <= btpc_pkg::SIZE_RESET;
			size_w_q    <= btpc_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (btpc_pkg::cfg_idx_t'(cfg_index))
				btpc_pkg::CFG_DIMENSION: dimension_q <= cfg_data[btpc_pkg::DIM_W-1:0];
				btpc_pkg::CFG_SIZE_X:    size_x_q    <= cfg_data;
				btpc_pkg::CFG_SIZE_Y:    size_y_q    <= cfg_data;
				btpc_pkg::CFG_SIZE_Z:    size_z_q    <= cfg_data;
				btpc_pkg::CFG_SIZE_W:    size_w_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Dimensions in use, clamped to 1..MAX_DIM
	always_comb begin
		dims = DW'(dimension_q);
		if (dims == '0) begin
			dims = DW'(1);
		end else if (dims > DW'(MAX_DIM)) begin
			dims = DW'(MAX_DIM);
		end
	end

	// Bits of this byte that lie inside the line
	always_comb begin
		base     = {pos_q, 3'b000};
		in_line  = base < size_x_q;
		diff     = size_x_q - base;
		line_end = (CMP_W'(base) + CMP_W'(8)) >= CMP_W'(size_x_q);
		for (int b = 0; b < btpc_pkg::BYTE_W; b++) begin
			bit_ok[b] = in_line && ((|diff[btpc_pkg::FIELD_W-1:3]) ||
			                        (diff[2:0] > btpc_pkg::BIT_IDX_W'(b)));
		end
		mask = data_byte & bit_ok;
	end

	// Higher coordinates from the row digits in use
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			coord[i] = '0;
		end
		for (int i = 0; i < NUM_DIGITS && i < 3; i++) begin
			if (DW'(i + 1) < dims) begin
				coord[i] = btpc_pkg::FIELD_W'(digit_q[i]);
			end
		end
		item.mask = mask;
		item.base = base;
		item.y    = coord[0];
		item.z    = coord[1];
		item.w    = coord[2];
	end

	// Mixed-radix row step: carry ripples while digits wrap
	always_comb begin
		logic                         carry;
		logic [CMP_W-1:0]             inc;
		logic [btpc_pkg::FIELD_W-1:0] radix;
		carry   = 1'b1;
		digit_d = digit_q;
		for (int i = 0; i < NUM_DIGITS; i++) begin
			radix = (i == 0) ? size_y_q : ((i == 1) ? size_z_q : size_w_q);
			inc   = CMP_W'(digit_q[i]) + CMP_W'(1);
			if (carry && (DW'(i + 1) < dims)) begin
				if (inc < CMP_W'(radix)) begin
					digit_d[i] = COORD_BITS'(inc);
					carry      = 1'b0;
				end else begin
					digit_d[i] = '0;
				end
			end else begin
				carry = 1'b0;
			end
		end
	end

	// Input transfer; bytes with nothing to emit skip the emitter
	assign in_ready = item_ready;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			digit_q <= '0;
		end else if (accept) begin
			if (line_end) begin
				pos_q   <= '0;
				digit_q <= digit_d;
			end else begin
				pos_q <= pos_q + 13'd1;
			end
		end
	end

	btpc_emit #(
		.COORD_BITS (COORD_BITS)
	) u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (in_valid && mask != '0),
		.item_ready   (item_ready),
		.item         (item),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.point_x      (point_x),
		.point_y      (point_y),
		.point_z      (point_z),
		.point_w      (point_w),
		.last_of_byte (last_of_byte)
	);

	// Checks
	`BTPC_ASSERT_NEXT(a_line_end_clears_pos, clk, arst_n, accept && line_end, pos_q == '0)
	`BTPC_ASSERT_NEXT(a_rows_hold_mid_line, clk, arst_n, accept && !line_end, $stable(digit_q))
	`BTPC_ASSERT_NEXT(a_idle_holds_pos, clk, arst_n, !accept, $stable(pos_q) && $stable(digit_q))

endmodule
